@@ hdl/mtm_pkg.sv @@
package mtm_pkg;

  localparam int MAX_TYPES = 32;
  localparam int MAX_HEAPS = 16;

  localparam int TYPE_AW = $clog2(MAX_TYPES);
  localparam int HEAP_AW = $clog2(MAX_HEAPS);
  localparam int CNT_W   = $clog2(MAX_TYPES + 1);

  localparam int ACTION_W = 3;
  localparam int INDEX_W  = 5;
  localparam int FLAG_W   = 32;
  localparam int SLOT_W   = 4;
  localparam int SIZE_W   = 64;
  localparam int COUNT_W  = 6;
  localparam int CFG_AW   = 2;

  localparam logic [ACTION_W-1:0] ACT_LD_SRC_TYPE = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_LD_SRC_HEAP = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_LD_TGT_TYPE = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_LD_TGT_HEAP = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_FIND        = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_CHECK       = 3'd5;

  localparam logic [CFG_AW-1:0] REG_SRC_COUNT = 2'd0;
  localparam logic [CFG_AW-1:0] REG_TGT_COUNT = 2'd1;
  localparam logic [CFG_AW-1:0] REG_MIN_HEAP  = 2'd2;

  localparam logic [SIZE_W-1:0] MIN_HEAP_RESET = 64'h0000_0000_4000_0000;
  localparam logic [FLAG_W-1:0] STRIP_MASK     = 32'h0000_00C0;
  localparam logic [FLAG_W-1:0] FLAGS_NONE_MAP = 32'h0000_0006;
  localparam logic [FLAG_W-1:0] FLAG_BIT0      = 32'h0000_0001;

endpackage

@@ hdl/mtm_req_if.sv @@
interface mtm_req_if;
  import mtm_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [INDEX_W-1:0]  entry_index;
  logic [FLAG_W-1:0]   type_flags;
  logic [SLOT_W-1:0]   heap_slot;
  logic [SIZE_W-1:0]   heap_bytes;
  logic                skip_heap_check;

  modport source (
    output valid, action, entry_index, type_flags, heap_slot, heap_bytes, skip_heap_check,
    input  ready
  );

  modport sink (
    input  valid, action, entry_index, type_flags, heap_slot, heap_bytes, skip_heap_check,
    output ready
  );

endinterface

@@ hdl/mtm_rsp_if.sv @@
interface mtm_rsp_if;
  import mtm_pkg::*;

  logic               valid;
  logic               ready;
  logic               found;
  logic [INDEX_W-1:0] match_index;
  logic               compatible;

  modport source (
    output valid, found, match_index, compatible,
    input  ready
  );

  modport sink (
    input  valid, found, match_index, compatible,
    output ready
  );

endinterface

@@ hdl/memory_type_matcher_core.sv @@
// Load items are written to the tables on acceptance and produce no result.
// Find item: reads the source entry, counts earlier equal-flag entries, then scans
// one target entry per cycle per pass, in up to three rounds (plain, stripped flags,
// remapped flags). Check item: tests each source entry against the same-index target.
// Throughput is one find or check item at a time; ready stays low until it is done.
// Synchronous reset clears counts and control, presets min heap; table contents kept.
module memory_type_matcher_core
  import mtm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  mtm_req_if.sink           req,
  mtm_rsp_if.source         rsp,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [SIZE_W-1:0] cfg_data
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_F_SRC0    = 4'd1;
  localparam logic [3:0] S_F_SRC1    = 4'd2;
  localparam logic [3:0] S_F_SIZE    = 4'd3;
  localparam logic [3:0] S_OCC_RD    = 4'd4;
  localparam logic [3:0] S_OCC_CMP   = 4'd5;
  localparam logic [3:0] S_SCAN_INIT = 4'd6;
  localparam logic [3:0] S_SCAN      = 4'd7;
  localparam logic [3:0] S_RETRY     = 4'd8;
  localparam logic [3:0] S_C_START   = 4'd9;
  localparam logic [3:0] S_C_RD      = 4'd10;
  localparam logic [3:0] S_C_FLAG    = 4'd11;
  localparam logic [3:0] S_C_CMP     = 4'd12;
  localparam logic [3:0] S_DONE      = 4'd13;

  logic [FLAG_W-1:0]  sflag_mem [MAX_TYPES];
  logic [SLOT_W-1:0]  shot_mem  [MAX_TYPES];
  logic [SIZE_W-1:0]  sheap_mem [MAX_HEAPS];
  logic [FLAG_W-1:0]  tflag_mem [MAX_TYPES];
  logic [SLOT_W-1:0]  thot_mem  [MAX_TYPES];
  logic [SIZE_W-1:0]  theap_mem [MAX_HEAPS];

  logic [FLAG_W-1:0]  sf_q;
  logic [SLOT_W-1:0]  sh_q;
  logic [SIZE_W-1:0]  sheap_q;
  logic [FLAG_W-1:0]  tf_q;
  logic [SLOT_W-1:0]  th_q;
  logic [SIZE_W-1:0]  theap_q;

  logic [COUNT_W-1:0] src_count;
  logic [COUNT_W-1:0] tgt_count;
  logic [SIZE_W-1:0]  min_heap;

  logic [3:0]         state;
  logic [INDEX_W-1:0] idx_q;
  logic               skip_q;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   occ;
  logic [CNT_W-1:0]   seen;
  logic [1:0]         pass;
  logic               any;
  logic               remapped;
  logic [TYPE_AW-1:0] pick;
  logic [FLAG_W-1:0]  cur_flags;
  logic [SIZE_W-1:0]  src_size;
  logic               sz_le_min;

  logic               s1_v;
  logic [TYPE_AW-1:0] s1_idx;
  logic               s2_v;
  logic [TYPE_AW-1:0] s2_idx;
  logic [FLAG_W-1:0]  tf2;

  logic               res_found;
  logic [INDEX_W-1:0] res_idx;
  logic               res_compat;

  logic               out_valid;
  logic               out_found;
  logic [INDEX_W-1:0] out_idx;
  logic               out_compat;

  logic               accept;
  logic [CNT_W-1:0]   ns_eff;
  logic [CNT_W-1:0]   nt_eff;
  logic [TYPE_AW-1:0] src_addr;
  logic [TYPE_AW-1:0] tgt_addr;
  logic               issue;
  logic               exact;
  logic               chk;
  logic               fok;
  logic               hok;
  logic               hit;
  logic [CNT_W-1:0]   seen_inc;
  logic               occ_hit;
  logic               drained;
  logic [FLAG_W-1:0]  stripped;
  logic [FLAG_W-1:0]  remap;

  assign accept = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);

  assign rsp.valid       = out_valid;
  assign rsp.found       = out_found;
  assign rsp.match_index = out_idx;
  assign rsp.compatible  = out_compat;

  assign ns_eff = (CNT_W'(src_count) > CNT_W'(MAX_TYPES)) ? CNT_W'(MAX_TYPES)
                                                          : CNT_W'(src_count);
  assign nt_eff = (CNT_W'(tgt_count) > CNT_W'(MAX_TYPES)) ? CNT_W'(MAX_TYPES)
                                                          : CNT_W'(tgt_count);

  assign src_addr = (state == S_F_SRC0) ? TYPE_AW'(idx_q) : cnt[TYPE_AW-1:0];
  assign tgt_addr = cnt[TYPE_AW-1:0];

  assign issue    = (cnt < nt_eff);
  assign exact    = !pass[0];
  assign chk      = !pass[1];
  assign fok      = exact ? (tf2 == cur_flags) : ((cur_flags & tf2) == cur_flags);
  assign hok      = chk ? (theap_q >= src_size) : ((theap_q >= min_heap) || sz_le_min);
  assign hit      = s2_v && fok && hok;
  assign seen_inc = seen + CNT_W'(1);
  assign occ_hit  = hit && (seen_inc == occ);
  assign drained  = !issue && !s1_v && !s2_v;

  assign stripped = cur_flags & ~STRIP_MASK;
  always_comb begin
    if (cur_flags == '0) begin
      remap = FLAGS_NONE_MAP;
    end else if (cur_flags[1:0] == 2'b11) begin
      remap = cur_flags & ~FLAG_BIT0;
    end else begin
      remap = cur_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (req.action == ACT_LD_SRC_TYPE) && (32'(req.entry_index) < MAX_TYPES)) begin
      sflag_mem[TYPE_AW'(req.entry_index)] <= req.type_flags;
      shot_mem[TYPE_AW'(req.entry_index)]  <= req.heap_slot;
    end
    sf_q <= sflag_mem[src_addr];
    sh_q <= shot_mem[src_addr];
  end

  always_ff @(posedge clk) begin
    if (accept && (req.action == ACT_LD_SRC_HEAP) && (32'(req.entry_index) < MAX_HEAPS)) begin
      sheap_mem[HEAP_AW'(req.entry_index)] <= req.heap_bytes;
    end
    sheap_q <= sheap_mem[HEAP_AW'(sh_q)];
  end

  always_ff @(posedge clk) begin
    if (accept && (req.action == ACT_LD_TGT_TYPE) && (32'(req.entry_index) < MAX_TYPES)) begin
      tflag_mem[TYPE_AW'(req.entry_index)] <= req.type_flags;
      thot_mem[TYPE_AW'(req.entry_index)]  <= req.heap_slot;
    end
    tf_q <= tflag_mem[tgt_addr];
    th_q <= thot_mem[tgt_addr];
  end

  always_ff @(posedge clk) begin
    if (accept && (req.action == ACT_LD_TGT_HEAP) && (32'(req.entry_index) < MAX_HEAPS)) begin
      theap_mem[HEAP_AW'(req.entry_index)] <= req.heap_bytes;
    end
    theap_q <= theap_mem[HEAP_AW'(th_q)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_count <= '0;
      tgt_count <= '0;
      min_heap  <= MIN_HEAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_COUNT: src_count <= cfg_data[COUNT_W-1:0];
        REG_TGT_COUNT: tgt_count <= cfg_data[COUNT_W-1:0];
        REG_MIN_HEAP:  min_heap  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      s1_v   <= 1'b0;
      s2_v   <= 1'b0;
      s1_idx <= tgt_addr;
      s2_idx <= s1_idx;
      tf2    <= tf_q;

      case (state)
        S_IDLE: begin
          if (accept) begin
            idx_q  <= req.entry_index;
            skip_q <= req.skip_heap_check;
            if (req.action == ACT_FIND) begin
              state <= S_F_SRC0;
            end else if (req.action == ACT_CHECK) begin
              state <= S_C_START;
            end
          end
        end

        S_F_SRC0: begin
          res_found  <= 1'b0;
          res_idx    <= '0;
          res_compat <= 1'b0;
          if (CNT_W'(idx_q) >= ns_eff) begin
            state <= S_DONE;
          end else begin
            state <= S_F_SRC1;
          end
        end

        S_F_SRC1: begin
          cur_flags <= sf_q;
          remapped  <= 1'b0;
          occ       <= CNT_W'(1);
          cnt       <= '0;
          state     <= S_F_SIZE;
        end

        S_F_SIZE: begin
          src_size  <= sheap_q;
          sz_le_min <= (sheap_q <= min_heap);
          pass      <= 2'd0;
          state     <= (idx_q == '0) ? S_SCAN_INIT : S_OCC_RD;
        end

        S_OCC_RD: begin
          state <= S_OCC_CMP;
        end

        S_OCC_CMP: begin
          if (sf_q == cur_flags) begin
            occ <= occ + CNT_W'(1);
          end
          cnt   <= cnt + CNT_W'(1);
          state <= ((cnt + CNT_W'(1)) == CNT_W'(idx_q)) ? S_SCAN_INIT : S_OCC_RD;
        end

        S_SCAN_INIT: begin
          cnt   <= '0;
          seen  <= '0;
          any   <= 1'b0;
          state <= S_SCAN;
        end

        S_SCAN: begin
          if (issue) begin
            cnt <= cnt + CNT_W'(1);
          end
          s1_v <= issue;
          s2_v <= s1_v;
          if (hit) begin
            seen <= seen_inc;
            pick <= s2_idx;
            any  <= 1'b1;
          end
          if (occ_hit) begin
            s1_v      <= 1'b0;
            s2_v      <= 1'b0;
            res_found <= 1'b1;
            res_idx   <= INDEX_W'(s2_idx);
            state     <= S_DONE;
          end else if (drained) begin
            if (any) begin
              res_found <= 1'b1;
              res_idx   <= INDEX_W'(pick);
              state     <= S_DONE;
            end else if (pass != 2'd3) begin
              pass  <= pass + 2'd1;
              state <= S_SCAN_INIT;
            end else begin
              state <= S_RETRY;
            end
          end
        end

        S_RETRY: begin
          pass <= 2'd0;
          if (remapped) begin
            state <= S_DONE;
          end else if ((stripped != '0) && (stripped != cur_flags)) begin
            cur_flags <= stripped;
            state     <= S_SCAN_INIT;
          end else if (remap != cur_flags) begin
            cur_flags <= remap;
            remapped  <= 1'b1;
            state     <= S_SCAN_INIT;
          end else begin
            state <= S_DONE;
          end
        end

        S_C_START: begin
          res_found  <= 1'b0;
          res_idx    <= '0;
          res_compat <= 1'b0;
          cnt        <= '0;
          if ((ns_eff == '0) || (ns_eff > nt_eff)) begin
            state <= S_DONE;
          end else begin
            state <= S_C_RD;
          end
        end

        S_C_RD: begin
          state <= S_C_FLAG;
        end

        S_C_FLAG: begin
          state <= ((sf_q & tf_q) == sf_q) ? S_C_CMP : S_DONE;
        end

        S_C_CMP: begin
          if (!skip_q && (sheap_q > theap_q)) begin
            state <= S_DONE;
          end else if ((cnt + CNT_W'(1)) == ns_eff) begin
            res_compat <= 1'b1;
            state      <= S_DONE;
          end else begin
            cnt   <= cnt + CNT_W'(1);
            state <= S_C_RD;
          end
        end

        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_found  <= res_found;
            out_idx    <= res_idx;
            out_compat <= res_compat;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_idx_zero_when_missing: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.found) |-> (rsp.match_index == '0))
    else $error("match index set without a match");

  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.found && rsp.compatible))
    else $error("find and check result mixed");

  a_seen_below_occ: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (seen < occ))
    else $error("scan ran past the wanted occurrence");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (cnt <= nt_eff))
    else $error("scan address beyond target count");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == S_SCAN) && (state == S_SCAN) |-> !$past(accept))
    else $error("item accepted during scan");

endmodule
